/* design/gtg_pkg.sv */
// Shared types, constants and the arctangent table of the go-to-goal controller.
`timescale 1ns / 1ps

package gtg_pkg;

   localparam int POSE_W      = 15;   // pose and goal coordinates, Q4.11
   localparam int HEAD_W      = 16;   // heading, signed Q3.13
   localparam int CFG_W       = 16;   // configuration data width
   localparam int OUT_W       = 16;   // result field width
   localparam int DELTA_W     = 16;   // goal minus pose, signed
   localparam int SQ_W        = 2 * (POSE_W);
   localparam int RAD_W       = 32;   // radicand of the square root
   localparam int ISQRT_STEPS = RAD_W / 2;
   localparam int VEC_SCALE   = 8;    // vector scaled by 256 before rotation
   localparam int VEC_W       = DELTA_W + VEC_SCALE + 3;
   localparam int ANG_W       = 35;   // CORDIC angle, Q.30 radians
   localparam int ANGLE_SHIFT = 17;   // Q.30 down to Q3.13
   localparam int BEARING_W   = ANG_W - ANGLE_SHIFT;
   localparam int CSR_INDEX_W = 3;

   localparam logic signed [ANG_W-1:0] PI_Q30    = 35'sd3373259426;
   localparam logic signed [ANG_W-1:0] ROUND_Q30 = 35'sd65536;

   localparam logic [CSR_INDEX_W-1:0] CSR_GOAL_X       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GOAL_Y       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_GAIN   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_LIMIT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIST_TOL     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_TOL     = 3'd5;

   localparam logic [POSE_W-1:0] GOAL_X_RESET      = 15'd2048;
   localparam logic [POSE_W-1:0] GOAL_Y_RESET      = 15'd2048;
   localparam logic [CFG_W-1:0]  SPEED_GAIN_RESET  = 16'd256;
   localparam logic [CFG_W-1:0]  SPEED_LIMIT_RESET = 16'd2048;
   localparam logic [CFG_W-1:0]  DIST_TOL_RESET    = 16'd205;
   localparam logic [CFG_W-1:0]  HEAD_TOL_RESET    = 16'd1638;

   typedef struct packed {
      logic [POSE_W-1:0] goal_x;
      logic [POSE_W-1:0] goal_y;
      logic [CFG_W-1:0]  speed_gain;
      logic [CFG_W-1:0]  speed_limit;
      logic [CFG_W-1:0]  dist_tol;
      logic [CFG_W-1:0]  head_tol;
   } cfg_type;

   // Work carried down the rotation and square-root steps
   typedef struct packed {
      logic signed [VEC_W-1:0]  x;
      logic signed [VEC_W-1:0]  y;
      logic signed [ANG_W-1:0]  z;
      logic [RAD_W-1:0]         rem;
      logic [RAD_W-1:0]         root;
      logic signed [HEAD_W-1:0] hd;
   } stage_type;

   function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned idx);
      logic signed [ANG_W-1:0] val;
      case (idx)
         0:       val = 35'sd843314857;
         1:       val = 35'sd497837829;
         2:       val = 35'sd263043837;
         3:       val = 35'sd133525159;
         4:       val = 35'sd67021687;
         5:       val = 35'sd33543516;
         6:       val = 35'sd16775851;
         7:       val = 35'sd8388437;
         8:       val = 35'sd4194283;
         9:       val = 35'sd2097149;
         10:      val = 35'sd1048576;
         11:      val = 35'sd524288;
         12:      val = 35'sd262144;
         13:      val = 35'sd131072;
         14:      val = 35'sd65536;
         15:      val = 35'sd32768;
         16:      val = 35'sd16384;
         17:      val = 35'sd8192;
         18:      val = 35'sd4096;
         19:      val = 35'sd2048;
         20:      val = 35'sd1024;
         21:      val = 35'sd512;
         22:      val = 35'sd256;
         23:      val = 35'sd128;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

/* design/gtg_if.sv */
// Pose, command and register-write channel interfaces.
`timescale 1ns / 1ps

interface gtg_req_if;
   logic                              valid;
   logic                              ready;
   logic [gtg_pkg::POSE_W-1:0]        pose_x;
   logic [gtg_pkg::POSE_W-1:0]        pose_y;
   logic signed [gtg_pkg::HEAD_W-1:0] heading;
   modport source (output valid, output pose_x, output pose_y, output heading, input ready);
   modport sink   (input valid, input pose_x, input pose_y, input heading, output ready);
endinterface

interface gtg_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [gtg_pkg::OUT_W-1:0] linear_speed;
   logic [gtg_pkg::OUT_W-1:0] turn_rate;
   modport source (output valid, output linear_speed, output turn_rate, input ready);
   modport sink   (input valid, input linear_speed, input turn_rate, output ready);
endinterface

interface gtg_csr_if;
   logic                            valid;
   logic                            ready;
   logic [gtg_pkg::CSR_INDEX_W-1:0] index;
   logic [gtg_pkg::CFG_W-1:0]       data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/gtg_front.sv */
// Front stages: offset to goal, squares and radicand, CORDIC pre-rotation.
`timescale 1ns / 1ps

module gtg_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic [gtg_pkg::POSE_W-1:0]        pose_x,
   input  logic [gtg_pkg::POSE_W-1:0]        pose_y,
   input  logic signed [gtg_pkg::HEAD_W-1:0] heading,
   input  gtg_pkg::cfg_type                  cfg,
   output logic                              out_valid,
   output gtg_pkg::stage_type                out_stage
);

   localparam int DW = gtg_pkg::DELTA_W;
   localparam int PW = gtg_pkg::POSE_W;
   localparam int SW = gtg_pkg::SQ_W;
   localparam int VW = gtg_pkg::VEC_W;

   // stage A: offsets
   logic                              a_valid_ff;
   logic signed [DW-1:0]              a_dx_ff, a_dx_in;
   logic signed [DW-1:0]              a_dy_ff, a_dy_in;
   logic signed [gtg_pkg::HEAD_W-1:0] a_hd_ff;

   // stage B: squares
   logic                              b_valid_ff;
   logic signed [DW-1:0]              b_dx_ff, b_dy_ff;
   logic signed [gtg_pkg::HEAD_W-1:0] b_hd_ff;
   logic [SW-1:0]                     b_sqx_ff, b_sqx_in;
   logic [SW-1:0]                     b_sqy_ff, b_sqy_in;
   logic [PW-1:0]                     abs_dx, abs_dy;

   // stage C: radicand and pre-rotated vector
   logic                              c_valid_ff;
   gtg_pkg::stage_type                c_stage_ff, c_stage_in;
   logic signed [VW-1:0]              vx, vy;

   assign a_dx_in = DW'({1'b0, cfg.goal_x}) - DW'({1'b0, pose_x});
   assign a_dy_in = DW'({1'b0, cfg.goal_y}) - DW'({1'b0, pose_y});

   always_comb begin
      abs_dx   = a_dx_ff[DW-1] ? PW'(-a_dx_ff) : a_dx_ff[PW-1:0];
      abs_dy   = a_dy_ff[DW-1] ? PW'(-a_dy_ff) : a_dy_ff[PW-1:0];
      b_sqx_in = SW'(abs_dx) * SW'(abs_dx);
      b_sqy_in = SW'(abs_dy) * SW'(abs_dy);
   end

   always_comb begin
      vx = {{(VW - DW - gtg_pkg::VEC_SCALE){b_dx_ff[DW-1]}}, b_dx_ff,
            {gtg_pkg::VEC_SCALE{1'b0}}};
      vy = {{(VW - DW - gtg_pkg::VEC_SCALE){b_dy_ff[DW-1]}}, b_dy_ff,
            {gtg_pkg::VEC_SCALE{1'b0}}};
      c_stage_in.rem  = gtg_pkg::RAD_W'(b_sqx_ff) + gtg_pkg::RAD_W'(b_sqy_ff);
      c_stage_in.root = '0;
      c_stage_in.hd   = b_hd_ff;
      // fold a vector in the left half plane over, starting from plus or minus pi
      if (b_dx_ff[DW-1]) begin
         c_stage_in.x = -vx;
         c_stage_in.y = -vy;
         c_stage_in.z = b_dy_ff[DW-1] ? -gtg_pkg::PI_Q30 : gtg_pkg::PI_Q30;
      end else begin
         c_stage_in.x = vx;
         c_stage_in.y = vy;
         c_stage_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_dx_ff    <= a_dx_in;
         a_dy_ff    <= a_dy_in;
         a_hd_ff    <= heading;
         b_dx_ff    <= a_dx_ff;
         b_dy_ff    <= a_dy_ff;
         b_hd_ff    <= a_hd_ff;
         b_sqx_ff   <= b_sqx_in;
         b_sqy_ff   <= b_sqy_in;
         c_stage_ff <= c_stage_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_stage = c_stage_ff;

endmodule

/* design/gtg_step.sv */
// One pipeline step: a CORDIC vectoring rotation and/or one bit of the square root, as its parameters enable.
`timescale 1ns / 1ps

module gtg_step #(
   parameter int STAGE     = 0,
   parameter bit DO_CORDIC = 1'b1,
   parameter bit DO_SQRT   = 1'b1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  gtg_pkg::stage_type in_stage,
   output logic               out_valid,
   output gtg_pkg::stage_type out_stage
);

   localparam int VW = gtg_pkg::VEC_W;
   localparam int RW = gtg_pkg::RAD_W;
   localparam logic signed [gtg_pkg::ANG_W-1:0] ATAN = gtg_pkg::atan_q30(STAGE);
   localparam int SQ_SHIFT = DO_SQRT ? (RW - 2 - 2 * STAGE) : 0;
   localparam logic [RW-1:0] SQ_BIT = {{(RW - 1){1'b0}}, 1'b1} << SQ_SHIFT;

   logic               valid_ff;
   gtg_pkg::stage_type stage_ff, stage_in;
   logic signed [VW-1:0] x, y, xs, ys;
   logic [RW-1:0]        trial;

   always_comb begin
      x        = in_stage.x;
      y        = in_stage.y;
      xs       = x >>> STAGE;
      ys       = y >>> STAGE;
      trial    = in_stage.root + SQ_BIT;
      stage_in = in_stage;
      if (DO_CORDIC) begin
         if (y > 0) begin
            stage_in.x = x + ys;
            stage_in.y = y - xs;
            stage_in.z = in_stage.z + ATAN;
         end else begin
            stage_in.x = x - ys;
            stage_in.y = y + xs;
            stage_in.z = in_stage.z - ATAN;
         end
      end
      if (DO_SQRT) begin
         if (in_stage.rem >= trial) begin
            stage_in.rem  = in_stage.rem - trial;
            stage_in.root = (in_stage.root >> 1) + SQ_BIT;
         end else begin
            stage_in.root = in_stage.root >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

/* design/gtg_back.sv */
// Back stages: heading error, distance saturation, speed product and command select.
`timescale 1ns / 1ps

module gtg_back #(
   parameter int POSITION_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  gtg_pkg::stage_type        in_stage,
   input  gtg_pkg::cfg_type          cfg,
   output logic                      out_valid,
   output logic [gtg_pkg::OUT_W-1:0] linear_speed,
   output logic [gtg_pkg::OUT_W-1:0] turn_rate
);

   localparam int BW     = gtg_pkg::BEARING_W;
   localparam int RW     = gtg_pkg::RAD_W;
   localparam int OW     = gtg_pkg::OUT_W;
   localparam int PROD_W = gtg_pkg::CFG_W + POSITION_WIDTH;
   localparam logic [RW-1:0] DIST_MAX = RW'((64'd1 << POSITION_WIDTH) - 64'd1);

   // stage D: error magnitude and distance
   logic                      d_valid_ff;
   logic [BW-1:0]             d_mag_ff, d_mag_in;
   logic [POSITION_WIDTH-1:0] d_dist_ff, d_dist_in;
   logic                      d_far_ff, d_far_in;
   logic signed [gtg_pkg::ANG_W-1:0] z_round;
   logic signed [BW-1:0]      bearing, err;

   // stage E: turn decision and speed product
   logic                      e_valid_ff;
   logic [BW-1:0]             e_mag_ff;
   logic                      e_far_ff;
   logic                      e_turn_ff, e_turn_in;
   logic [PROD_W-1:0]         e_prod_ff, e_prod_in;

   // stage F: output register
   logic                      f_valid_ff;
   logic [OW-1:0]             f_speed_ff, f_speed_in;
   logic [OW-1:0]             f_turn_ff, f_turn_in;
   logic [PROD_W-9:0]         speed_full;

   always_comb begin
      z_round   = in_stage.z + gtg_pkg::ROUND_Q30;
      bearing   = z_round[gtg_pkg::ANG_W-1:gtg_pkg::ANGLE_SHIFT];
      err       = bearing - BW'(in_stage.hd);
      d_mag_in  = err[BW-1] ? BW'(-err) : BW'(err);
      d_dist_in = (in_stage.root > DIST_MAX) ? {POSITION_WIDTH{1'b1}}
                                             : in_stage.root[POSITION_WIDTH-1:0];
      d_far_in  = RW'(d_dist_in) > RW'(cfg.dist_tol);
   end

   always_comb begin
      e_turn_in = d_mag_ff > BW'(cfg.head_tol);
      e_prod_in = PROD_W'(cfg.speed_gain) * PROD_W'(d_dist_ff);
   end

   always_comb begin
      speed_full = e_prod_ff[PROD_W-1:8];
      f_speed_in = '0;
      f_turn_in  = '0;
      if (e_far_ff) begin
         if (e_turn_ff) begin
            f_turn_in = e_mag_ff[OW-1:0];
         end else if (PROD_W'(speed_full) > PROD_W'(cfg.speed_limit)) begin
            f_speed_in = cfg.speed_limit;
         end else begin
            f_speed_in = speed_full[OW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= in_valid;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_mag_ff   <= d_mag_in;
         d_dist_ff  <= d_dist_in;
         d_far_ff   <= d_far_in;
         e_mag_ff   <= d_mag_ff;
         e_far_ff   <= d_far_ff;
         e_turn_ff  <= e_turn_in;
         e_prod_ff  <= e_prod_in;
         f_speed_ff <= f_speed_in;
         f_turn_ff  <= f_turn_in;
      end
   end

   assign out_valid    = f_valid_ff;
   assign linear_speed = f_speed_ff;
   assign turn_rate    = f_turn_ff;

endmodule

/* design/go_to_goal_velocity.sv */
// An accepted pose beat passes front stages A-C, the step chain and back stages D-F to its command beat.
// Throughput: one pose per cycle while not stalled; the depth is set by the longer of the CORDIC
// rotation chain and the 16 bit-steps of the distance square root, run side by side.
// A command waiting at the output holds every stage; nothing is dropped or repeated.
// Reset (synchronous) clears all valid bits and loads the register defaults.
// Register writes are taken in every cycle.
`timescale 1ns / 1ps

module go_to_goal_velocity #(
   parameter int CORDIC_STAGES  = 16,
   parameter int POSITION_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   gtg_req_if.sink   req,
   gtg_rsp_if.source rsp,
   gtg_csr_if.sink   csr
);

   localparam int STEP_COUNT = (CORDIC_STAGES > gtg_pkg::ISQRT_STEPS) ?
                               CORDIC_STAGES : gtg_pkg::ISQRT_STEPS;

   gtg_pkg::cfg_type   cfg_ff;
   logic               advance;
   logic               chain_valid [STEP_COUNT+1];
   gtg_pkg::stage_type chain_stage [STEP_COUNT+1];
   logic               out_valid;

   // the whole pipeline moves unless a finished beat is stuck at the output
   assign advance   = !out_valid || rsp.ready;
   assign req.ready = advance;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.goal_x      <= gtg_pkg::GOAL_X_RESET;
         cfg_ff.goal_y      <= gtg_pkg::GOAL_Y_RESET;
         cfg_ff.speed_gain  <= gtg_pkg::SPEED_GAIN_RESET;
         cfg_ff.speed_limit <= gtg_pkg::SPEED_LIMIT_RESET;
         cfg_ff.dist_tol    <= gtg_pkg::DIST_TOL_RESET;
         cfg_ff.head_tol    <= gtg_pkg::HEAD_TOL_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            gtg_pkg::CSR_GOAL_X:      cfg_ff.goal_x      <= csr.data[gtg_pkg::POSE_W-1:0];
            gtg_pkg::CSR_GOAL_Y:      cfg_ff.goal_y      <= csr.data[gtg_pkg::POSE_W-1:0];
            gtg_pkg::CSR_SPEED_GAIN:  cfg_ff.speed_gain  <= csr.data;
            gtg_pkg::CSR_SPEED_LIMIT: cfg_ff.speed_limit <= csr.data;
            gtg_pkg::CSR_DIST_TOL:    cfg_ff.dist_tol    <= csr.data;
            gtg_pkg::CSR_HEAD_TOL:    cfg_ff.head_tol    <= csr.data;
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   gtg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req.valid),
      .pose_x    (req.pose_x),
      .pose_y    (req.pose_y),
      .heading   (req.heading),
      .cfg       (cfg_ff),
      .out_valid (chain_valid[0]),
      .out_stage (chain_stage[0])
   );

   for (genvar i = 0; i < STEP_COUNT; i++) begin : g_step
      gtg_step #(
         .STAGE     (i),
         .DO_CORDIC (i < CORDIC_STAGES),
         .DO_SQRT   (i < gtg_pkg::ISQRT_STEPS)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[i]),
         .in_stage  (chain_stage[i]),
         .out_valid (chain_valid[i+1]),
         .out_stage (chain_stage[i+1])
      );
   end

   gtg_back #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (chain_valid[STEP_COUNT]),
      .in_stage     (chain_stage[STEP_COUNT]),
      .cfg          (cfg_ff),
      .out_valid    (out_valid),
      .linear_speed (rsp.linear_speed),
      .turn_rate    (rsp.turn_rate)
   );

   assign rsp.valid = out_valid;

endmodule

/* tb/sv/velocity_command_check.sv */
// Checker for the go-to-goal controller: predicts each velocity command and compares.
`timescale 1ns / 1ps

module velocity_command_check
   import gtg_pkg::*;
#(
   parameter int CORDIC_STAGES  = 16,
   parameter int POSITION_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   gtg_req_if   req,
   gtg_rsp_if   rsp,
   gtg_csr_if   csr,
   output int   mismatch_count,
   output int   commands_outstanding,
   output int   commands_checked
);

   localparam int     REPORT_CAP   = 40;
   localparam int     ARCTAN_STEPS = 24;
   localparam longint HALF_TURN    = 64'sd3373259426;   // pi in Q.30

   localparam longint ARCTAN_Q30 [ARCTAN_STEPS] = '{
      843314857, 497837829, 263043837, 133525159,
      67021687, 33543516, 16775851, 8388437,
      4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048,
      1024, 512, 256, 128
   };

   typedef struct packed {
      logic [OUT_W-1:0] linear_speed;
      logic [OUT_W-1:0] turn_rate;
   } velocity_cmd_type;

   cfg_type          settings;
   velocity_cmd_type awaited_cmds[$];
   velocity_cmd_type oldest;

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned root;
      longint unsigned bit_w;
      root  = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v)
         bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= root + bit_w) begin
            v    = v - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return root;
   endfunction

   // Vectoring rotation towards the x axis; left half-plane starts at +/- pi
   function automatic longint bearing_q13(longint dx, longint dy);
      longint x, y, z, xs, ys;
      int     i;
      if (dx == 0 && dy == 0)
         return 0;
      x = dx * 256;
      y = dy * 256;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? HALF_TURN : -HALF_TURN;
         x = -x;
         y = -y;
      end
      for (i = 0; i < CORDIC_STAGES && i < ARCTAN_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ARCTAN_Q30[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ARCTAN_Q30[i];
         end
      end
      return (z + 64'sd65536) >>> 17;
   endfunction

   function automatic velocity_cmd_type predict_command(cfg_type s, logic [POSE_W-1:0] px,
                                                        logic [POSE_W-1:0] py,
                                                        logic signed [HEAD_W-1:0] hd);
      longint           dx, dy, err;
      longint unsigned  dist_q11, dist_cap, mag, speed, turn;
      velocity_cmd_type cmd;
      dx       = longint'(s.goal_x) - longint'(px);
      dy       = longint'(s.goal_y) - longint'(py);
      dist_cap = (64'd1 << POSITION_WIDTH) - 1;
      dist_q11 = floor_root(dx * dx + dy * dy);
      if (dist_q11 > dist_cap)
         dist_q11 = dist_cap;
      speed = 0;
      turn  = 0;
      if (dist_q11 > s.dist_tol) begin
         err = bearing_q13(dx, dy) - longint'(hd);
         mag = (err < 0) ? -err : err;
         if (mag > s.head_tol)
            turn = mag;
         else
            speed = (s.speed_gain * dist_q11) >> 8;
      end
      if (speed > s.speed_limit)
         speed = s.speed_limit;
      cmd.linear_speed = speed[OUT_W-1:0];
      cmd.turn_rate    = turn[OUT_W-1:0];
      return cmd;
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
         $display("%0t: %s", $time, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         settings.goal_x      = GOAL_X_RESET;
         settings.goal_y      = GOAL_Y_RESET;
         settings.speed_gain  = SPEED_GAIN_RESET;
         settings.speed_limit = SPEED_LIMIT_RESET;
         settings.dist_tol    = DIST_TOL_RESET;
         settings.head_tol    = HEAD_TOL_RESET;
         awaited_cmds.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_GOAL_X:      settings.goal_x      = csr.data[POSE_W-1:0];
               CSR_GOAL_Y:      settings.goal_y      = csr.data[POSE_W-1:0];
               CSR_SPEED_GAIN:  settings.speed_gain  = csr.data;
               CSR_SPEED_LIMIT: settings.speed_limit = csr.data;
               CSR_DIST_TOL:    settings.dist_tol    = csr.data;
               CSR_HEAD_TOL:    settings.head_tol    = csr.data;
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            awaited_cmds.push_back(predict_command(settings, req.pose_x, req.pose_y,
                                                   req.heading));
         if (rsp.valid && rsp.ready) begin
            if (awaited_cmds.size() == 0) begin
               report_mismatch($sformatf("command beat %0d arrived with no pose outstanding",
                                         commands_checked));
            end else begin
               oldest = awaited_cmds.pop_front();
               if (rsp.linear_speed !== oldest.linear_speed)
                  report_mismatch($sformatf("command %0d linear_speed got %0d, want %0d",
                                            commands_checked, rsp.linear_speed,
                                            oldest.linear_speed));
               if (rsp.turn_rate !== oldest.turn_rate)
                  report_mismatch($sformatf("command %0d turn_rate got %0d, want %0d",
                                            commands_checked, rsp.turn_rate,
                                            oldest.turn_rate));
            end
            commands_checked++;
         end
      end
      commands_outstanding = awaited_cmds.size();
   end

endmodule

/* tb/sv/go_to_goal_velocity_tb.sv */
// Top of the go-to-goal controller testbench: clock, reset, pose and register stimulus, verdict.
`timescale 1ns / 1ps

module go_to_goal_velocity_tb;
   import gtg_pkg::*;

   localparam int CORDIC_STAGES  = 16;
   localparam int POSITION_WIDTH = 16;
   localparam int PIPE_LATENCY   = ((CORDIC_STAGES > 16) ? CORDIC_STAGES : 16) + 6;
   localparam int SETTLE_CYCLES  = PIPE_LATENCY + 10;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int RANDOM_PHASES  = 7;

   // Indexes that decode to no register
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_CADENCE, READY_RUNS} ready_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gtg_req_if req_ch ();
   gtg_rsp_if rsp_ch ();
   gtg_csr_if csr_ch ();

   int          mismatch_count;
   int          commands_outstanding;
   int          commands_checked;
   int          poses_sent;
   int          writes_done;
   int          burst_left;
   int unsigned cycle_count = 0;
   int          cur_goal_x, cur_goal_y, cur_dist_tol, cur_head_tol;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   go_to_goal_velocity #(
      .CORDIC_STAGES (CORDIC_STAGES),
      .POSITION_WIDTH(POSITION_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   velocity_command_check #(
      .CORDIC_STAGES (CORDIC_STAGES),
      .POSITION_WIDTH(POSITION_WIDTH)
   ) command_check (
      .clock               (clock),
      .reset               (reset),
      .req                 (req_ch),
      .rsp                 (rsp_ch),
      .csr                 (csr_ch),
      .mismatch_count      (mismatch_count),
      .commands_outstanding(commands_outstanding),
      .commands_checked    (commands_checked)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped by the cycle limit at %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // Command side back-pressure, changing style at random
   initial begin
      ready_style_type style;
      int              style_left, run_left, tick;
      rsp_ch.ready = 1'b0;
      style        = READY_ALWAYS;
      style_left   = 0;
      run_left     = 0;
      tick         = 0;
      forever begin
         @(negedge clock);
         if (style_left == 0) begin
            style      = ready_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(40, 300);
         end
         style_left--;
         tick++;
         case (style)
            READY_ALWAYS:  rsp_ch.ready = 1'b1;
            READY_COIN:    rsp_ch.ready = 1'($urandom_range(0, 1));
            READY_CADENCE: rsp_ch.ready = ((tick % 7) < 4);
            default: begin
               if (run_left == 0) begin
                  rsp_ch.ready = !rsp_ch.ready;
                  run_left     = $urandom_range(1, 20);
               end
               run_left--;
            end
         endcase
      end
   end

   // Called at a falling edge; returns at a falling edge with the beat taken
   task automatic send_pose(int x, int y, int h);
      int gap;
      req_ch.pose_x  = x[POSE_W-1:0];
      req_ch.pose_y  = y[POSE_W-1:0];
      req_ch.heading = h[HEAD_W-1:0];
      req_ch.valid   = 1'b1;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      @(negedge clock);
      poses_sent++;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         req_ch.valid = 1'b0;
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 24);
      end
   endtask

   // Hold off until every command is back and the pipeline is empty
   task automatic settle();
      req_ch.valid = 1'b0;
      while (commands_outstanding != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CFG_W-1:0] data);
      csr_ch.index = index;
      csr_ch.data  = data;
      csr_ch.valid = 1'b1;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      @(negedge clock);
      writes_done++;
   endtask

   task automatic apply_settings(int gx, int gy, int gain, int lim, int dtol, int htol);
      settle();
      if ($urandom_range(0, 1) == 1)
         write_reg(($urandom_range(0, 1) == 1) ? CSR_SPARE_A : CSR_SPARE_B,
                   16'($urandom_range(0, 65535)));
      // Spare top bit on the goal writes is dropped by the block
      write_reg(CSR_GOAL_X, {1'($urandom_range(0, 1)), gx[POSE_W-1:0]});
      write_reg(CSR_GOAL_Y, {1'($urandom_range(0, 1)), gy[POSE_W-1:0]});
      write_reg(CSR_SPEED_GAIN, gain[CFG_W-1:0]);
      write_reg(CSR_SPEED_LIMIT, lim[CFG_W-1:0]);
      write_reg(CSR_DIST_TOL, dtol[CFG_W-1:0]);
      write_reg(CSR_HEAD_TOL, htol[CFG_W-1:0]);
      csr_ch.valid = 1'b0;
      cur_goal_x   = gx;
      cur_goal_y   = gy;
      cur_dist_tol = dtol;
      cur_head_tol = htol;
   endtask

   task automatic random_settings();
      int gx, gy, gain, lim, dtol, htol;
      gx   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 24576);
      gy   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 24576);
      gain = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(32, 1024);
      lim  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(256, 8192);
      dtol = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1500);
      htol = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 51472);
      apply_settings(gx, gy, gain, lim, dtol, htol);
   endtask

   // Mostly poses aimed near the goal bearing, so both sides of the heading limit get hit
   task automatic make_pose(output int x, output int y, output int h);
      int  kind, span, off;
      real ang, rad;
      kind = $urandom_range(0, 99);
      x    = $urandom_range(0, 24576);
      y    = $urandom_range(0, 24576);
      h    = $urandom_range(0, 51472) - 25736;
      if (kind < 12) begin
         rad = real'(cur_dist_tol) + real'($urandom_range(0, 8)) - 4.0;
         ang = real'($urandom_range(0, 62831)) / 10000.0;
         x   = int'(real'(cur_goal_x) - rad * $cos(ang));
         y   = int'(real'(cur_goal_y) - rad * $sin(ang));
      end else if (kind < 70) begin
         if ($urandom_range(0, 3) == 0) begin
            x = cur_goal_x + $urandom_range(0, 1024) - 512;
            y = cur_goal_y + $urandom_range(0, 1024) - 512;
         end
         case ($urandom_range(0, 9))
            0:       x = cur_goal_x;
            1:       y = cur_goal_y;
            default: ;
         endcase
         span = cur_head_tol + 40;
         if (span > 60000)
            span = 60000;
         off = $urandom_range(0, 2 * span) - span;
         h   = int'($atan2(real'(cur_goal_y - y), real'(cur_goal_x - x)) * 8192.0) + off;
      end else if (kind >= 88) begin
         x = $urandom_range(0, 32767);
         y = $urandom_range(0, 32767);
         h = $urandom_range(0, 65535) - 32768;
      end
      if (x < 0) x = 0;
      if (x > 32767) x = 32767;
      if (y < 0) y = 0;
      if (y > 32767) y = 32767;
   endtask

   task automatic run_phase(int count);
      int x, y, h;
      repeat (count) begin
         make_pose(x, y, h);
         send_pose(x, y, h);
      end
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.pose_x  = '0;
      req_ch.pose_y  = '0;
      req_ch.heading = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = '0;
      csr_ch.data    = '0;
      poses_sent     = 0;
      writes_done    = 0;
      burst_left     = 8;
      cur_goal_x     = GOAL_X_RESET;
      cur_goal_y     = GOAL_Y_RESET;
      cur_dist_tol   = DIST_TOL_RESET;
      cur_head_tol   = HEAD_TOL_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: goal at (1.0, 1.0), stop radius 0.1, heading limit 0.2
      send_pose(2048, 2048, 0);          // pose on the goal
      send_pose(2253, 2048, 0);          // exactly on the stop radius
      send_pose(1842, 2048, 0);          // just outside, drive forward
      send_pose(1842, 2048, 1638);       // heading error at the limit
      send_pose(1842, 2048, 1639);       // just over, turn in place
      send_pose(1842, 2048, -1639);
      send_pose(0, 0, 6434);             // diagonal, speed clamped
      send_pose(0, 0, -6434);
      send_pose(4096, 2048, 25736);      // goal behind on the x axis
      send_pose(4096, 2049, -25736);     // behind and below
      send_pose(4096, 2047, 25736);      // behind and above
      send_pose(2048, 0, 0);             // straight up, turn
      send_pose(2048, 4096, -12868);     // straight down, drive
      send_pose(24576, 24576, 0);
      send_pose(32767, 32767, -32768);
      send_pose(0, 32767, 32767);
      send_pose(32767, 0, -25736);
      send_pose(0, 2048, 0);             // speed equal to the limit
      send_pose(2047, 2048, 0);
      send_pose(0, 24576, -25736);

      // Register extremes
      apply_settings(0, 0, 65535, 65535, 0, 0);
      run_phase(60);
      apply_settings(24576, 24576, 0, 0, 65535, 51472);
      run_phase(40);
      apply_settings(32767, 32767, 65535, 2048, 0, 65535);
      run_phase(60);

      repeat (RANDOM_PHASES) begin
         random_settings();
         run_phase(250);
      end

      settle();
      $display("Covered %0d pose beats and %0d register writes; %0d commands compared",
               poses_sent, writes_done, commands_checked);
      $display("Settings ran from reset values through zero and full-scale extremes to %0d %s",
               RANDOM_PHASES, "random phases");
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
